@@ hw/rtl/bra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg: shared constants for the bitmap range allocator
// Sizes, reset values and status and operation codes.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned IdBitsDefault      = 16;
  localparam int unsigned FreeEntriesDefault = 8;
  localparam int unsigned MaxRequestDefault  = 256;
  localparam int unsigned WordBitsDefault    = 32;
  localparam logic [15:0] FirstOidReset      = 16'd3000;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoRun    = 2'd1;
  localparam logic [1:0] StatusConflict = 2'd2;

  localparam logic OpAlloc  = 1'b0;
  localparam logic OpReinit = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/bra_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bra_req_if / bra_rsp_if: valid-ready channels of the allocator
// Request carries operation and size; response carries status, ID and count.
// ----------------------------------------------------------------------------
interface bra_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [8:0] request_count;
  modport source (output valid, operation, request_count, input ready);
  modport sink   (input valid, operation, request_count, output ready);
endinterface

interface bra_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] first_id;
  logic [16:0] used_count;
  modport source (output valid, status, first_id, used_count, input ready);
  modport sink   (input valid, status, first_id, used_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bra_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] addr_i,
  input  wire  [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read the addressed word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/bitmap_range_allocator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_range_allocator_core: allocator of runs of consecutive IDs
// Bitmap in RAM, a best-fit free list of ranges and a sequencer.
// ----------------------------------------------------------------------------
// One item at a time. After reset, and for every reinitialize beat, a sweep
// rewrites all 2^ID_BITS/WORD_BITS bitmap words (2048 by default), one word a
// cycle; no item is accepted meanwhile. An allocate beat walks the free list,
// one entry a cycle, until an exact fit or the end of the list. A free-list
// hit then checks each word the run touches and afterwards marks each of those
// words (a wait and a check state per word for the check, a read and a write
// state per word for the mark). With no hit the bitmap is scanned one bit a
// cycle from ID 0, with a read state before each new word, until a run is
// found or the top ID is reached. It then checks and trims the list (one entry
// a cycle each) and marks the run. The result is held in an output register
// until taken.
module bitmap_range_allocator_core
  import bra_pkg::*;
#(
  parameter int unsigned IdBits      = IdBitsDefault,
  parameter int unsigned FreeEntries = FreeEntriesDefault,
  parameter int unsigned MaxRequest  = MaxRequestDefault,
  parameter int unsigned WordBits    = WordBitsDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [15:0] cfg_wdata_i,
  bra_req_if.sink    req,
  bra_rsp_if.source  rsp
);
  localparam int unsigned Words = (2 ** IdBits + WordBits - 1) / WordBits;
  localparam int unsigned WaW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW    = (WordBits > 1) ? $clog2(WordBits) : 1;
  localparam int unsigned EW    = (FreeEntries > 1) ? $clog2(FreeEntries) : 1;
  localparam int unsigned IW    = IdBits + 1;
  localparam logic [IW-1:0] Space = IW'(2 ** IdBits);
  localparam logic [IW-1:0] TopId = Space - IW'(1);
  localparam logic [WaW-1:0] LastW = WaW'(Words - 1);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SInit   = 4'd1;
  localparam logic [3:0] SSearch = 4'd2;
  localparam logic [3:0] SClaimR = 4'd3;
  localparam logic [3:0] SClaimC = 4'd4;
  localparam logic [3:0] SMarkR  = 4'd5;
  localparam logic [3:0] SMarkW  = 4'd6;
  localparam logic [3:0] SScanR  = 4'd7;
  localparam logic [3:0] SScanB  = 4'd8;
  localparam logic [3:0] SChk    = 4'd9;
  localparam logic [3:0] STrim   = 4'd10;
  localparam logic [3:0] SDone   = 4'd11;
  localparam logic [3:0] SWaitR  = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [15:0]   first_oid_q;
  logic [IW-1:0] rb_q [FreeEntries];
  logic [IW-1:0] re_q [FreeEntries];
  logic [FreeEntries-1:0] rv_q;
  logic [IW:0]   used_q;
  logic [IW-1:0] num_q, start_q, id_q, run_q, bsize_q;
  logic [EW:0]   idx_q;
  logic [EW-1:0] best_q;
  logic          hit_q, hold_q;
  logic [1:0]    st_q;
  logic [15:0]   fid_q;
  logic          ovalid_q;
  logic [WaW-1:0] waddr_q;
  logic [WordBits-1:0] wdata;
  logic          we;
  logic [WordBits-1:0] rdata;
  logic [IW-1:0] reserved;

  assign reserved = (32'(first_oid_q) >= 32'(Space)) ? Space : IW'(first_oid_q);

  bra_ram #(.Width(WordBits), .Depth(Words)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (waddr_q),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // shared unit: entry index, current ID bit, word mask of run within word
  logic [EW-1:0]  ei;
  logic [IW:0]    esize;
  logic [BW-1:0]  bit_sel;
  logic [IW-1:0]  runend;
  logic [WordBits-1:0] mask;
  logic [IW-1:0]  wbase;
  assign ei      = idx_q[EW-1:0];
  assign esize   = {1'b0, re_q[ei]} - {1'b0, rb_q[ei]} + (IW+1)'(1);
  assign bit_sel = BW'(id_q % IW'(WordBits));
  assign runend  = start_q + num_q - IW'(1);
  assign wbase   = IW'(waddr_q) * IW'(WordBits);
  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      mask[b] = (wbase + IW'(b) >= start_q) && (wbase + IW'(b) <= runend);
    end
  end

  // bitmap write data: init sweep builds reserved pattern, mark ORs mask
  always_comb begin
    we = 1'b0;
    wdata = rdata | mask;
    if (state_q == SInit) begin
      we = 1'b1;
      for (int b = 0; b < WordBits; b++) begin
        wdata[b] = (wbase + IW'(b)) < reserved;
      end
    end else if (state_q == SMarkW) begin
      we = 1'b1;
    end
  end

  logic in_fire;
  assign in_fire = req.valid && req.ready;
  assign req.ready = (state_q == SIdle) && !ovalid_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SInit;
      first_oid_q <= FirstOidReset;
      waddr_q     <= '0;
      ovalid_q    <= 1'b0;
      hold_q      <= 1'b1;
      rv_q        <= '0;
      used_q      <= '0;
      idx_q <= '0; best_q <= '0; hit_q <= 1'b0; st_q <= StatusOk; fid_q <= '0;
      num_q <= '0; start_q <= '0; id_q <= '0; run_q <= '0;
      bsize_q <= '0;
      for (int i = 0; i < FreeEntries; i++) begin
        rb_q[i] <= '0;
        re_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        first_oid_q <= cfg_wdata_i;
      end
      if (rsp.valid && rsp.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_fire) begin
            num_q <= IW'(req.request_count);
            fid_q <= '0;
            if (req.operation == OpReinit) begin
              st_q    <= StatusOk;
              waddr_q <= '0;
              hold_q  <= 1'b0;
              state_q <= SInit;
            end else if (req.request_count == 9'd0 ||
                         32'(req.request_count) > MaxRequest) begin
              st_q  <= StatusConflict;
              state_q <= SDone;
            end else begin
              st_q  <= StatusOk;
              idx_q <= '0; hit_q <= 1'b0; bsize_q <= '1;
              state_q <= SSearch;
            end
          end
        end
        SInit: begin
          waddr_q <= waddr_q + WaW'(1);
          if (waddr_q == LastW) begin
            // entry 0 spans the free space, if any; all others drop
            for (int i = 0; i < FreeEntries; i++) begin
              rb_q[i] <= (i == 0 && reserved < Space) ? reserved : '0;
              re_q[i] <= (i == 0 && reserved < Space) ? TopId : '0;
              rv_q[i] <= (i == 0) && (reserved < Space);
            end
            used_q <= {1'b0, reserved};
            st_q <= StatusOk; fid_q <= '0;
            state_q <= hold_q ? SIdle : SDone;
            hold_q <= 1'b0;
          end
        end
        SSearch: begin
          // one free-list entry a cycle; exact size ends the search
          if (32'(idx_q) >= FreeEntries) begin
            if (hit_q) begin
              start_q <= rb_q[best_q];
              if ({1'b0, re_q[best_q]} - {1'b0, rb_q[best_q]} + (IW+1)'(1)
                  == {1'b0, num_q}) begin
                rv_q[best_q] <= 1'b0; rb_q[best_q] <= '0; re_q[best_q] <= '0;
              end else begin
                rb_q[best_q] <= (rb_q[best_q] + num_q) & TopId;
              end
              state_q <= SClaimR;
            end else begin
              id_q <= '0; run_q <= '0; waddr_q <= '0;
              state_q <= SScanR;
            end
          end else if (rv_q[ei] && !esize[IW] && esize[IW-1:0] == num_q) begin
            best_q <= ei; hit_q <= 1'b1;
            idx_q <= (EW+1)'(FreeEntries);
          end else begin
            idx_q <= idx_q + (EW+1)'(1);
            if (rv_q[ei] && !esize[IW] && esize[IW-1:0] > num_q &&
                esize[IW-1:0] < bsize_q) begin
              best_q <= ei; hit_q <= 1'b1; bsize_q <= esize[IW-1:0];
            end
          end
        end
        SClaimR: begin
          if ({1'b0, start_q} + {1'b0, num_q} - (IW+1)'(1) > {1'b0, TopId}) begin
            st_q <= StatusConflict; state_q <= SDone;
          end else begin
            waddr_q <= WaW'(start_q / IW'(WordBits));
            state_q <= SWaitR;
          end
        end
        SWaitR: state_q <= SClaimC;
        SClaimC: begin
          // check one word for used bits in the run
          if ((rdata & mask) != '0) begin
            st_q <= StatusConflict; state_q <= SDone;
          end else if (wbase + IW'(WordBits) > runend) begin
            waddr_q <= WaW'(start_q / IW'(WordBits));
            state_q <= SMarkR;
          end else begin
            waddr_q <= waddr_q + WaW'(1);
            state_q <= SWaitR;
          end
        end
        SMarkR: state_q <= SMarkW;
        SMarkW: begin
          if (wbase + IW'(WordBits) > runend) begin
            used_q <= used_q + {1'b0, num_q};
            fid_q  <= start_q[15:0];
            state_q <= SDone;
          end else begin
            waddr_q <= waddr_q + WaW'(1);
            state_q <= SMarkR;
          end
        end
        SScanR: state_q <= SScanB;
        SScanB: begin
          // one bit a cycle, with a read state before each new word
          if (rdata[bit_sel]) begin
            run_q <= '0;
          end else if (run_q + IW'(1) == num_q) begin
            start_q <= id_q + IW'(1) - num_q;
            idx_q <= '0;
            state_q <= SChk;
          end else begin
            run_q <= run_q + IW'(1);
          end
          if (!(!rdata[bit_sel] && run_q + IW'(1) == num_q)) begin
            if (id_q == TopId) begin
              st_q <= StatusNoRun; state_q <= SDone;
            end else begin
              id_q <= id_q + IW'(1);
              if (32'(bit_sel) == WordBits - 1) begin
                waddr_q <= waddr_q + WaW'(1);
                state_q <= SScanR;
              end
            end
          end
        end
        SChk: begin
          if (32'(idx_q) >= FreeEntries) begin
            idx_q <= '0; state_q <= STrim;
          end else begin
            idx_q <= idx_q + (EW+1)'(1);
            if (rv_q[ei] && !(start_q <= rb_q[ei] && runend >= rb_q[ei]) &&
                start_q >= rb_q[ei] && runend <= re_q[ei]) begin
              st_q <= StatusConflict; state_q <= SDone;
            end
          end
        end
        STrim: begin
          if (32'(idx_q) >= FreeEntries) begin
            waddr_q <= WaW'(start_q / IW'(WordBits));
            state_q <= SMarkR;
          end else begin
            idx_q <= idx_q + (EW+1)'(1);
            if (rv_q[ei] && start_q <= rb_q[ei] && runend >= rb_q[ei]) begin
              if (runend < re_q[ei]) begin
                rb_q[ei] <= runend + IW'(1);
              end else begin
                rv_q[ei] <= 1'b0; rb_q[ei] <= '0; re_q[ei] <= '0;
              end
            end
          end
        end
        SDone: begin
          ovalid_q <= 1'b1;
          state_q  <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign rsp.valid      = ovalid_q;
  assign rsp.status     = st_q;
  assign rsp.first_id   = fid_q;
  assign rsp.used_count = 17'(used_q);

  // no new beat while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp.valid |-> !req.ready)
    else $error("request accepted with result pending");
  // failures report no ID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != StatusOk |-> rsp.first_id == '0)
    else $error("nonzero ID with failure status");
  // bitmap only written while sweeping or marking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == SInit || state_q == SMarkW))
    else $error("stray bitmap write");
endmodule
`default_nettype wire

@@ dv/tb_bitmap_range_allocator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bitmap_range_allocator_core: self-checking bench for the range allocator
// Drives allocate and reinitialize beats, predicts every response from its own
// copy of bitmap, free list and used count, and checks each response in order.
// ----------------------------------------------------------------------------
module tb_bitmap_range_allocator_core;
  import bra_pkg::*;

  localparam int unsigned IdSpace  = 65536;
  localparam int unsigned TopId    = 65535;
  localparam int unsigned ListSize = 8;
  localparam int unsigned ReqMax   = 256;
  localparam int unsigned Settle   = 100;

  typedef enum logic [1:0] {KindBeat, KindCfg, KindDrain} stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    logic        op;
    logic [8:0]  cnt;
    logic [15:0] data;
  } stim_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] first_id;
    logic [16:0] used_count;
  } alloc_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  bra_req_if req_if ();
  bra_rsp_if rsp_if ();

  bitmap_range_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // Shadow allocator state
  bit [TopId:0]  shadow_used;
  logic [15:0]   fl_begin [ListSize];
  logic [15:0]   fl_end   [ListSize];
  bit            fl_valid [ListSize];
  int unsigned   shadow_total;
  logic [15:0]   shadow_first_oid;

  stim_t         stim_q[$];
  alloc_rsp_t    expected_rsp_q[$];
  int            fails = 0;
  int            quiet_cycles = 0;
  int            send_gap = 0;
  int            recv_gap = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req_if.valid         = 1'b0;
    req_if.operation     = OpAlloc;
    req_if.request_count = '0;
    rsp_if.ready         = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  function automatic void rebuild_shadow();
    int unsigned reserved;
    reserved = shadow_first_oid;
    for (int unsigned id = 0; id < IdSpace; id++) shadow_used[id] = (id < reserved);
    for (int i = 0; i < ListSize; i++) begin
      fl_begin[i] = '0;
      fl_end[i]   = '0;
      fl_valid[i] = 1'b0;
    end
    fl_begin[0]  = reserved[15:0];
    fl_end[0]    = TopId[15:0];
    fl_valid[0]  = 1'b1;
    shadow_total = reserved;
  endfunction

  function automatic logic [1:0] claim_ids(int unsigned start, int unsigned num);
    if (start + num - 1 > TopId) return StatusConflict;
    for (int unsigned k = 0; k < num; k++)
      if (shadow_used[start + k]) return StatusConflict;
    for (int unsigned k = 0; k < num; k++) shadow_used[start + k] = 1'b1;
    shadow_total += num;
    return StatusOk;
  endfunction

  // Best-fit list search, then lowest-run bitmap scan
  function automatic logic [1:0] alloc_ids(int unsigned num, output int unsigned first);
    int best;
    longint best_size;
    longint size;
    int unsigned run;
    int unsigned start;
    int unsigned stop;
    bit found;
    logic [1:0] st;
    best = -1;
    best_size = 64'sh7fff_ffff_ffff_ffff;
    run = 0;
    start = 0;
    found = 1'b0;
    first = 0;
    if (num == 0 || num > ReqMax) return StatusConflict;
    for (int i = 0; i < ListSize; i++) begin
      if (!fl_valid[i]) continue;
      size = longint'(fl_end[i]) - longint'(fl_begin[i]) + 1;
      if (size == longint'(num)) begin
        best = i;
        break;
      end
      if (size > longint'(num) && size < best_size) begin
        best = i;
        best_size = size;
      end
    end
    if (best >= 0) begin
      start = fl_begin[best];
      if (longint'(fl_end[best]) - longint'(start) + 1 == longint'(num)) begin
        fl_valid[best] = 1'b0;
        fl_begin[best] = '0;
        fl_end[best]   = '0;
      end else begin
        fl_begin[best] = 16'(start + num);
      end
      st = claim_ids(start, num);
      if (st == StatusOk) first = start;
      return st;
    end
    for (int unsigned id = 0; id < IdSpace; id++) begin
      if (shadow_used[id]) begin
        run = 0;
      end else begin
        run++;
        if (run == num) begin
          start = id + 1 - num;
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) return StatusNoRun;
    stop = start + num - 1;
    for (int i = 0; i < ListSize; i++) begin
      if (!fl_valid[i]) continue;
      if (!(start <= fl_begin[i] && stop >= fl_begin[i]) &&
          start >= fl_begin[i] && stop <= fl_end[i])
        return StatusConflict;
    end
    for (int i = 0; i < ListSize; i++) begin
      if (!fl_valid[i]) continue;
      if (start <= fl_begin[i] && stop >= fl_begin[i]) begin
        if (stop < fl_end[i]) begin
          fl_begin[i] = 16'(stop + 1);
        end else begin
          fl_valid[i] = 1'b0;
          fl_begin[i] = '0;
          fl_end[i]   = '0;
        end
      end
    end
    void'(claim_ids(start, num));
    first = start;
    return StatusOk;
  endfunction

  function automatic alloc_rsp_t predict_rsp(logic op, logic [8:0] cnt);
    alloc_rsp_t r;
    int unsigned first;
    first = 0;
    r.status = StatusOk;
    if (op == OpReinit) begin
      rebuild_shadow();
    end else begin
      r.status = alloc_ids(cnt, first);
      if (r.status != StatusOk) first = 0;
    end
    r.first_id   = first[15:0];
    r.used_count = shadow_total[16:0];
    return r;
  endfunction

  // Driver: issue queued beats, config writes and drain waits
  always @(posedge clk_i or negedge rst_ni) begin
    logic        v_n;
    logic        op_n;
    logic [8:0]  cnt_n;
    logic        we_n;
    logic [15:0] wd_n;
    bit          tail;
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.operation     <= OpAlloc;
      req_if.request_count <= '0;
      cfg_we_i             <= 1'b0;
      cfg_wdata_i          <= '0;
    end else begin
      v_n   = req_if.valid;
      op_n  = req_if.operation;
      cnt_n = req_if.request_count;
      we_n  = 1'b0;
      wd_n  = cfg_wdata_i;
      tail  = stim_q.size() < 150;
      // Record the accepted beat and its expected response
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(predict_rsp(req_if.operation, req_if.request_count));
        void'(stim_q.pop_front());
        v_n = 1'b0;
      end
      if (expected_rsp_q.size() == 0 && !req_if.valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (req_if.valid && !req_if.ready) begin
        // hold the beat until taken
      end else if (send_gap > 0) begin
        send_gap--;
        v_n = 1'b0;
      end else if (stim_q.size() > 0) begin
        case (stim_q[0].kind)
          KindBeat: begin
            if (!tail && $urandom_range(0, 7) == 0) begin
              send_gap = $urandom_range(1, 12) - 1;
              v_n = 1'b0;
            end else begin
              v_n   = 1'b1;
              op_n  = stim_q[0].op;
              cnt_n = stim_q[0].cnt;
            end
          end
          KindCfg: begin
            v_n = 1'b0;
            if (expected_rsp_q.size() == 0 && quiet_cycles >= Settle) begin
              we_n = 1'b1;
              wd_n = stim_q[0].data;
              shadow_first_oid = stim_q[0].data;
              void'(stim_q.pop_front());
              quiet_cycles = 0;
            end
          end
          default: begin
            v_n = 1'b0;
            if (expected_rsp_q.size() == 0) void'(stim_q.pop_front());
          end
        endcase
      end
      req_if.valid         <= v_n;
      req_if.operation     <= op_n;
      req_if.request_count <= cnt_n;
      cfg_we_i             <= we_n;
      cfg_wdata_i          <= wd_n;
    end
  end

  // Monitor: take responses with random stalls and check each field
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report("unexpected beat, status", rsp_if.status, -1);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_if.status !== want.status) report("status", rsp_if.status, want.status);
          if (rsp_if.first_id !== want.first_id)
            report("first_id", rsp_if.first_id, want.first_id);
          if (rsp_if.used_count !== want.used_count)
            report("used_count", rsp_if.used_count, want.used_count);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else if (stim_q.size() >= 150 && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 12) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  function automatic void push_beat(logic op, logic [8:0] cnt);
    stim_t s;
    s.kind = KindBeat;
    s.op   = op;
    s.cnt  = cnt;
    s.data = '0;
    stim_q.push_back(s);
  endfunction

  function automatic void push_ctl(stim_kind_e kind, logic [15:0] data);
    stim_t s;
    s.kind = kind;
    s.op   = OpAlloc;
    s.cnt  = '0;
    s.data = data;
    stim_q.push_back(s);
  endfunction

  // Stimulus: directed corners, then reinit-led random sequences
  initial begin
    int beats;
    int n;
    int pick;
    shadow_first_oid = FirstOidReset;
    rebuild_shadow();

    push_beat(OpAlloc, 9'd1);
    push_beat(OpAlloc, 9'd256);
    push_beat(OpAlloc, 9'd0);
    push_beat(OpAlloc, 9'd511);
    push_beat(OpAlloc, 9'd257);
    push_beat(OpReinit, 9'd0);
    // one-ID space at the top: exact hit, then a failing scan
    push_ctl(KindCfg, 16'hffff);
    push_beat(OpReinit, 9'd1);
    push_beat(OpAlloc, 9'd1);
    push_beat(OpAlloc, 9'd1);
    // shrink the top entry until the list no longer fits
    push_ctl(KindCfg, 16'd65000);
    push_beat(OpReinit, 9'h1ff);
    push_beat(OpAlloc, 9'd256);
    push_beat(OpAlloc, 9'd256);
    push_beat(OpAlloc, 9'd100);
    // nothing reserved
    push_ctl(KindCfg, 16'd0);
    push_beat(OpReinit, 9'd0);
    push_beat(OpAlloc, 9'd256);
    push_beat(OpAlloc, 9'd255);
    push_beat(OpAlloc, 9'd128);
    push_beat(OpAlloc, 9'd1);
    push_ctl(KindDrain, '0);

    beats = 0;
    while (beats < 1950) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 5);
        push_ctl(KindCfg, pick == 0 ? 16'd0 : pick == 1 ? 16'd60000 :
                 16'($urandom_range(0, 60000)));
      end
      push_beat(OpReinit, 9'($urandom));
      beats++;
      n = $urandom_range(5, 20);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) push_beat(OpReinit, 9'($urandom));
        else if (pick < 10) push_beat(OpAlloc, $urandom_range(0, 1) ? 9'd0 :
                                      9'($urandom_range(257, 511)));
        else if (pick < 55) push_beat(OpAlloc, 9'($urandom_range(1, 16)));
        else push_beat(OpAlloc, 9'($urandom_range(1, 256)));
        beats++;
      end
      if ($urandom_range(0, 15) == 0) push_ctl(KindDrain, '0);
    end

    wait (rst_ni);
    while (stim_q.size() > 0 || expected_rsp_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fails == 0) begin
      $display("bitmap_range_allocator_core regression: pass");
    end else begin
      $display("bitmap_range_allocator_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("bitmap_range_allocator_core regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/bra_pkg.sv
hw/rtl/bra_if.sv
hw/rtl/bra_ram.sv
hw/rtl/bitmap_range_allocator_core.sv
dv/tb_bitmap_range_allocator_core.sv
